FILE: rtl/core/swip_pkg.sv
// Package for the selector width integer packer.
// Holds the sizes, selector tables, width function and sequencer state type.
// Has no dependencies; it is used by selector_width_integer_packer_unit.
package swip_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int WID_W       = 5;
    localparam int SEL_W       = 4;
    localparam int SPAN_W      = 3;
    localparam int DELTA_W     = 4;
    localparam int LA_DEPTH    = 4;
    localparam int LA_IDX_W    = 2;
    localparam int CNT_W       = 3;
    localparam int NBYTE_W     = 5;
    localparam int MAX_BYTES   = 16;
    localparam int START_WIDTH = 8;
    localparam int BYTE_W      = 8;

    localparam logic [SEL_W-1:0] SEL_FALLBACK = 4'd0;
    localparam logic [SEL_W-1:0] SEL_LAST     = 4'd15;

    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic [SPAN_W-1:0]         span_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_PUT,
        ST_END,
        ST_FIN
    } state_t;

    function automatic delta_t sel_delta(input logic [SEL_W-1:0] sel);
        delta_t d;
        case (sel)
            4'd1:    d = -4'sd4;
            4'd2:    d = -4'sd2;
            4'd3:    d = -4'sd2;
            4'd4:    d = -4'sd1;
            4'd5:    d = -4'sd1;
            4'd6:    d = -4'sd1;
            4'd10:   d = 4'sd1;
            4'd11:   d = 4'sd1;
            4'd12:   d = 4'sd1;
            4'd13:   d = 4'sd2;
            4'd14:   d = 4'sd2;
            4'd15:   d = 4'sd4;
            default: d = 4'sd0;
        endcase
        return d;
    endfunction

    function automatic span_t sel_span(input logic [SEL_W-1:0] sel);
        span_t s;
        case (sel)
            4'd3:    s = 3'd2;
            4'd5:    s = 3'd2;
            4'd6:    s = 3'd4;
            4'd8:    s = 3'd2;
            4'd9:    s = 3'd4;
            4'd11:   s = 3'd2;
            4'd12:   s = 3'd4;
            4'd14:   s = 3'd2;
            default: s = 3'd1;
        endcase
        return s;
    endfunction

    function automatic logic [WID_W-1:0] width_of(input logic [SAMPLE_W-1:0] v);
        logic [WID_W-1:0] w;
        w = '0;
        for (int i = 0; i < SAMPLE_W; i++) begin
            if (v[i]) begin
                w = WID_W'(i + 1);
            end
        end
        return w;
    endfunction

endpackage

FILE: rtl/core/selector_width_integer_packer_unit.sv
// A transaction that only buffers a sample leaves the block in idle. Each group of a full
// lookahead or an array end takes a scan over all sixteen selectors, a set-up step, the
// selector field and the sample fields, each completed byte and a closing step; an array
// end adds a padding step and the final byte. Input is taken only in idle, not during a
// group; the output byte is registered, so a new input is taken while it waits.
// Reset (aresetn low, synchronous) empties the lookahead and restores running width 8.
module selector_width_integer_packer_unit #(
    parameter int MAX_WIDTH = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [swip_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                          s_carries_sample,
    input  logic                          s_array_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [swip_pkg::BYTE_W-1:0]   m_packed_byte,
    output logic                          m_final_byte
);
    import swip_pkg::*;

    localparam int RW_W    = $clog2(MAX_WIDTH + 1);
    localparam int CW_W    = RW_W + 2;
    localparam int SCORE_W = RW_W + 4;
    localparam int ACC_W   = MAX_WIDTH + 8;
    localparam int ACNT_W  = $clog2(ACC_W + 1);

    state_t                     state_reg, state_next;
    logic [SAMPLE_W-1:0]        values_reg [LA_DEPTH];
    logic [SAMPLE_W-1:0]        values_next [LA_DEPTH];
    logic [WID_W-1:0]           widths_reg [LA_DEPTH];
    logic [WID_W-1:0]           widths_next [LA_DEPTH];
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [RW_W-1:0]            rw_reg, rw_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [ACNT_W-1:0]          acnt_reg, acnt_next;
    logic                       last_reg, last_next;
    logic [NBYTE_W-1:0]         nbytes_reg, nbytes_next;
    logic [SEL_W-1:0]           sel_reg, sel_next;
    logic [SEL_W-1:0]           best_reg, best_next;
    logic signed [SCORE_W-1:0]  score_reg, score_next;
    logic [SPAN_W-1:0]          fld_reg, fld_next;
    logic                       m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]          m_byte_reg, m_byte_next;
    logic                       m_final_reg, m_final_next;

    logic                       in_fire;
    logic [CNT_W-1:0]           new_count;
    logic [LA_IDX_W-1:0]        slot;
    logic                       have_byte;
    logic                       drop;
    logic                       can_emit;
    logic                       emit_now;
    logic [SPAN_W-1:0]          cur_span;
    logic                       group_done;
    logic [SPAN_W-1:0]          cand_span;
    logic signed [CW_W-1:0]     cand_w;
    logic signed [CW_W-1:0]     apply_w;
    logic                       cand_ok;
    logic                       cand_fits;
    logic signed [SCORE_W-1:0]  cand_waste;
    logic signed [SCORE_W-1:0]  cand_score;
    logic signed [SCORE_W-1:0]  score_init;
    logic                       cand_take;
    logic [ACC_W-1:0]           val_mask;
    logic [ACNT_W-1:0]          end_len;
    logic [ACC_W-1:0]           end_bits;

    assign s_ready       = (state_reg == ST_IDLE);
    assign in_fire       = s_valid && s_ready;
    assign new_count     = count_reg + CNT_W'(s_carries_sample);
    assign slot          = count_reg[LA_IDX_W-1:0];
    assign have_byte     = (acnt_reg >= ACNT_W'(BYTE_W));
    assign drop          = (nbytes_reg == NBYTE_W'(MAX_BYTES));
    assign can_emit      = drop || !m_valid_reg || m_ready;
    assign emit_now      = have_byte && can_emit && (state_reg == ST_PUT || state_reg == ST_FIN);
    assign cur_span      = sel_span(best_reg);
    assign group_done    = !have_byte && (fld_reg > cur_span);
    assign m_valid       = m_valid_reg;
    assign m_packed_byte = m_byte_reg;
    assign m_final_byte  = m_final_reg;

    // Shared candidate evaluator: one selector per scan cycle.
    always_comb begin
        cand_span  = sel_span(sel_reg);
        cand_w     = $signed({2'b00, rw_reg}) + CW_W'(sel_delta(sel_reg));
        apply_w    = $signed({2'b00, rw_reg}) + CW_W'(sel_delta(best_reg));
        cand_ok    = (cand_span <= count_reg) && (cand_w >= 0)
                     && (cand_w <= $signed(CW_W'(MAX_WIDTH)));
        cand_fits  = 1'b1;
        cand_waste = '0;
        for (int k = 0; k < LA_DEPTH; k++) begin
            if (SPAN_W'(k) < cand_span) begin
                if ($signed(SCORE_W'(widths_reg[k])) > SCORE_W'(cand_w)) begin
                    cand_fits = 1'b0;
                end
                cand_waste = cand_waste + SCORE_W'(cand_w) - $signed(SCORE_W'(widths_reg[k]));
            end
        end
        cand_score = $signed(SCORE_W'({cand_span - SPAN_W'(1), 2'b00})) - cand_waste;
        score_init = $signed(SCORE_W'(widths_reg[0])) - $signed(SCORE_W'(MAX_WIDTH));
        cand_take  = cand_ok && cand_fits && (cand_score > score_reg);
        val_mask   = ~({ACC_W{1'b1}} << rw_reg);
        end_len    = ACNT_W'(BYTE_W) - acnt_reg;
        end_bits   = (ACC_W'(1) << (end_len - ACNT_W'(1))) - ACC_W'(1);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_array_end) begin
                        state_next = (new_count != '0) ? ST_SCAN : ST_END;
                    end else if (s_carries_sample && new_count == CNT_W'(LA_DEPTH)) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (sel_reg == SEL_LAST) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                state_next = ST_PUT;
            end
            ST_PUT: begin
                if (group_done) begin
                    if (!last_reg) begin
                        state_next = ST_IDLE;
                    end else if (count_reg != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (can_emit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        values_next  = values_reg;
        widths_next  = widths_reg;
        count_next   = count_reg;
        rw_next      = rw_reg;
        acc_next     = acc_reg;
        acnt_next    = acnt_reg;
        last_next    = last_reg;
        nbytes_next  = nbytes_reg;
        sel_next     = '0;
        best_next    = best_reg;
        score_next   = score_reg;
        fld_next     = fld_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_byte_next  = m_byte_reg;
        m_final_next = m_final_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    nbytes_next = '0;
                    last_next   = s_array_end;
                    if (s_carries_sample) begin
                        values_next[slot] = s_sample;
                        widths_next[slot] = width_of(s_sample);
                        count_next        = new_count;
                    end
                end
            end
            ST_SCAN: begin
                sel_next = sel_reg + SEL_W'(1);
                if (sel_reg == SEL_FALLBACK) begin
                    best_next  = SEL_FALLBACK;
                    score_next = score_init;
                end else if (cand_take) begin
                    best_next  = sel_reg;
                    score_next = cand_score;
                end
            end
            ST_APPLY: begin
                rw_next  = (best_reg == SEL_FALLBACK) ? RW_W'(MAX_WIDTH) : RW_W'(apply_w);
                fld_next = '0;
            end
            ST_PUT: begin
                if (!have_byte) begin
                    if (fld_reg == '0) begin
                        acc_next  = (acc_reg << SEL_W) | ACC_W'(best_reg);
                        acnt_next = acnt_reg + ACNT_W'(SEL_W);
                        fld_next  = SPAN_W'(1);
                    end else if (fld_reg <= cur_span) begin
                        acc_next  = (acc_reg << rw_reg) | (ACC_W'(values_reg[0]) & val_mask);
                        acnt_next = acnt_reg + ACNT_W'(rw_reg);
                        fld_next  = fld_reg + SPAN_W'(1);
                        count_next = count_reg - CNT_W'(1);
                        for (int k = 0; k < LA_DEPTH - 1; k++) begin
                            values_next[k] = values_reg[k + 1];
                            widths_next[k] = widths_reg[k + 1];
                        end
                    end
                end
            end
            ST_END: begin
                acc_next  = (acc_reg << end_len) | end_bits;
                acnt_next = ACNT_W'(BYTE_W);
            end
            ST_FIN: begin
                if (can_emit) begin
                    count_next = '0;
                    rw_next    = RW_W'(START_WIDTH);
                    last_next  = 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (emit_now) begin
            acnt_next = acnt_reg - ACNT_W'(BYTE_W);
            if (!drop) begin
                nbytes_next  = nbytes_reg + NBYTE_W'(1);
                m_valid_next = 1'b1;
                m_byte_next  = BYTE_W'(acc_reg >> (acnt_reg - ACNT_W'(BYTE_W)));
                m_final_next = (state_reg == ST_FIN);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rw_reg      <= RW_W'(START_WIDTH);
            acnt_reg    <= '0;
            last_reg    <= 1'b0;
            nbytes_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rw_reg      <= rw_next;
            acnt_reg    <= acnt_next;
            last_reg    <= last_next;
            nbytes_reg  <= nbytes_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        values_reg  <= values_next;
        widths_reg  <= widths_next;
        acc_reg     <= acc_next;
        sel_reg     <= sel_next;
        best_reg    <= best_next;
        score_reg   <= score_next;
        fld_reg     <= fld_next;
        m_byte_reg  <= m_byte_next;
        m_final_reg <= m_final_next;
    end

endmodule

FILE: rtl/core/swip_checker.sv
// Port-level checks for selector_width_integer_packer_unit.
// Watches only the top level's ports; attached by the bind statement below.
module swip_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_carries_sample,
    input logic s_array_end,
    input logic m_valid,
    input logic m_ready,
    input logic [7:0] m_packed_byte,
    input logic m_final_byte
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packed_byte) && $stable(m_final_byte))
        else $error("Stalled output transaction changed.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Output valid after reset.");

    a_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_array_end |=> !s_ready)
        else $error("Ready straight after an end-of-array transaction.");

    a_empty_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_carries_sample && !s_array_end |=> s_ready)
        else $error("An empty transaction left the block busy.");

endmodule

bind selector_width_integer_packer_unit swip_checker u_swip_checker (.*);

FILE: tb/sv/selector_width_integer_packer_checker.sv
// Checker for selector_width_integer_packer_unit: watches both channels, predicts the packed
// byte stream of every accepted input transaction and compares it with the output transactions.
// Depends on swip_pkg for the field widths and selector codes.
`timescale 1ns / 1ps

module selector_width_integer_packer_checker #(
    parameter int MAX_WIDTH = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [swip_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                          s_carries_sample,
    input  logic                          s_array_end,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [swip_pkg::BYTE_W-1:0]   m_packed_byte,
    input  logic                          m_final_byte,
    output int                            mismatches,
    output int                            pending
);

    typedef struct packed {
        logic [swip_pkg::BYTE_W-1:0] data;
        logic                        last;
    } stream_byte_t;

    localparam int WIDTH_CHANGE [0:15] = '{0, -4, -2, -2, -1, -1, -1, 0, 0, 0, 1, 1, 1, 2, 2, 4};
    localparam int GROUP_SPAN [0:15]   = '{1, 1, 1, 2, 1, 2, 4, 1, 2, 4, 1, 2, 4, 1, 2, 1};

    stream_byte_t                expected_bytes[$];
    logic [swip_pkg::SAMPLE_W-1:0] held_value [swip_pkg::LA_DEPTH];
    int                          held_width [swip_pkg::LA_DEPTH];
    int                          held_count;
    int                          run_width;
    logic [swip_pkg::BYTE_W-1:0] acc_byte;
    int                          acc_pos;
    int                          step_bytes;

    assign pending = expected_bytes.size();

    function automatic int bit_width(input logic [swip_pkg::SAMPLE_W-1:0] v);
        int n;
        n = 0;
        while (v != '0) begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    task automatic restart_stream();
        held_count = 0;
        run_width  = swip_pkg::START_WIDTH;
        acc_byte   = '0;
        acc_pos    = 7;
    endtask

    task automatic append_bit(input logic b, input logic fin);
        stream_byte_t done;
        if (b) begin
            acc_byte[acc_pos] = 1'b1;
        end
        if (acc_pos == 0) begin
            if (step_bytes < swip_pkg::MAX_BYTES) begin
                done.data = acc_byte;
                done.last = fin;
                expected_bytes = {expected_bytes, done};
                step_bytes++;
            end
            acc_byte = '0;
            acc_pos  = 7;
        end else begin
            acc_pos--;
        end
    endtask

    task automatic append_field(input logic [31:0] v, input int n);
        int i;
        for (i = n - 1; i >= 0; i--) begin
            append_bit(v[i], 1'b0);
        end
    endtask

    task automatic pack_group();
        int  best;
        int  score;
        int  sel;
        int  k;
        int  w;
        int  waste;
        int  sp;
        bit  fits;
        best  = swip_pkg::SEL_FALLBACK;
        score = held_width[0] - MAX_WIDTH;
        for (sel = 1; sel <= swip_pkg::SEL_LAST; sel++) begin
            sp = GROUP_SPAN[sel];
            w  = run_width + WIDTH_CHANGE[sel];
            if (sp <= held_count && w >= 0 && w <= MAX_WIDTH) begin
                fits  = 1'b1;
                waste = 0;
                for (k = 0; k < sp; k++) begin
                    if (held_width[k] > w) begin
                        fits = 1'b0;
                    end
                    waste += w - held_width[k];
                end
                if (fits && (sp - 1) * 4 - waste > score) begin
                    best  = sel;
                    score = (sp - 1) * 4 - waste;
                end
            end
        end
        if (best == swip_pkg::SEL_FALLBACK) begin
            run_width = MAX_WIDTH;
        end else begin
            run_width += WIDTH_CHANGE[best];
        end
        sp = GROUP_SPAN[best];
        append_field(32'(best), swip_pkg::SEL_W);
        if (run_width > 0) begin
            for (k = 0; k < sp; k++) begin
                append_field(32'(held_value[k]), run_width);
            end
        end
        held_count -= sp;
        for (k = 0; k + sp < swip_pkg::LA_DEPTH; k++) begin
            held_value[k] = held_value[k + sp];
            held_width[k] = held_width[k + sp];
        end
    endtask

    task automatic predict_packing(input logic [swip_pkg::SAMPLE_W-1:0] sample,
                                   input logic carries, input logic last);
        int slot;
        step_bytes = 0;
        if (carries) begin
            slot             = held_count % swip_pkg::LA_DEPTH;
            held_value[slot] = sample;
            held_width[slot] = bit_width(sample);
            held_count++;
            if (held_count >= swip_pkg::LA_DEPTH && !last) begin
                pack_group();
            end
        end
        if (last) begin
            while (held_count > 0) begin
                pack_group();
            end
            append_bit(1'b0, 1'b1);
            while (acc_pos != 7) begin
                append_bit(1'b1, 1'b1);
            end
            restart_stream();
        end
    endtask

    task automatic note_mismatch(input string what);
        if (mismatches < 10) begin
            $display("%0t %s", $realtime, what);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin
        stream_byte_t want;
        if (!aresetn) begin
            mismatches = 0;
            expected_bytes.delete();
            restart_stream();
        end else begin
            if (s_valid && s_ready) begin
                predict_packing(s_sample, s_carries_sample, s_array_end);
            end
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    note_mismatch($sformatf("unexpected transaction: byte %02h final %0b",
                                            m_packed_byte, m_final_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.data !== m_packed_byte || want.last !== m_final_byte) begin
                        note_mismatch($sformatf(
                            "mismatch: expected byte %02h final %0b, got byte %02h final %0b",
                            want.data, want.last, m_packed_byte, m_final_byte));
                    end
                end
            end
        end
    end

endmodule

FILE: tb/sv/selector_width_integer_packer_unit_test.sv
// Top of the testbench for selector_width_integer_packer_unit: drives directed and random
// arrays with random idling on both channels and gives the verdict.
// Depends on swip_pkg and selector_width_integer_packer_checker.
`timescale 1ns / 1ps

module selector_width_integer_packer_unit_test;

    localparam int MAX_WIDTH    = 24;
    localparam int RANDOM_ITEMS = 330;
    localparam int CYCLE_LIMIT  = 2000000;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [swip_pkg::SAMPLE_W-1:0] s_sample;
    logic                          s_carries_sample;
    logic                          s_array_end;
    logic                          m_valid;
    logic                          m_ready;
    logic [swip_pkg::BYTE_W-1:0]   m_packed_byte;
    logic                          m_final_byte;
    int                            mismatches;
    int                            pending;
    int                            cycle_count = 0;
    int                            items_sent;
    int                            width_centre;
    bit                            no_gaps;

    selector_width_integer_packer_unit #(
        .MAX_WIDTH(MAX_WIDTH)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_carries_sample(s_carries_sample),
        .s_array_end     (s_array_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packed_byte   (m_packed_byte),
        .m_final_byte    (m_final_byte)
    );

    selector_width_integer_packer_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_carries_sample(s_carries_sample),
        .s_array_end     (s_array_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packed_byte   (m_packed_byte),
        .m_final_byte    (m_final_byte),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[selector_width_integer_packer_unit] ERROR");
            $finish;
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(16, 40);
    endfunction

    initial begin
        int r;
        m_ready = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else if (r < 80) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(16, 40)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(100, 300)) @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic [swip_pkg::SAMPLE_W-1:0] sample,
                             input logic carries, input logic last);
        int gap;
        gap = no_gaps ? 0 : idle_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_sample         <= sample;
        s_carries_sample <= carries;
        s_array_end      <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (carries || last) begin
            items_sent++;
        end
    endtask

    task automatic drain_stream();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic [swip_pkg::SAMPLE_W-1:0] sample_of_width(input int w);
        logic [31:0] v;
        if (w <= 0) begin
            return '0;
        end
        v        = $urandom & ((32'd1 << w) - 1);
        v[w - 1] = 1'b1;
        return v[swip_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic send_random_array();
        int   len;
        int   mode;
        int   fixed_width;
        int   w;
        int   j;
        int   r;
        bit   end_on_sample;
        logic [swip_pkg::SAMPLE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            len = 0;
        end else if (r < 85) begin
            len = $urandom_range(1, 12);
        end else begin
            len = $urandom_range(16, 40);
        end
        mode          = $urandom_range(0, 3);
        fixed_width   = $urandom_range(0, swip_pkg::SAMPLE_W);
        end_on_sample = (len > 0) && ($urandom_range(0, 1) == 1);
        no_gaps       = ($urandom_range(0, 4) == 0);
        for (j = 0; j < len; j++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(swip_pkg::SAMPLE_W'($urandom), 1'b0, 1'b0);
            end
            if (mode <= 1) begin
                width_centre += $urandom_range(0, 4) - 2;
                if (width_centre < 0) width_centre = 0;
                if (width_centre > swip_pkg::SAMPLE_W) width_centre = swip_pkg::SAMPLE_W;
                w = width_centre;
                if ($urandom_range(0, 9) < 3) begin
                    w += $urandom_range(0, 2) - 1;
                end
            end else if (mode == 2) begin
                w = $urandom_range(0, swip_pkg::SAMPLE_W);
            end else begin
                w = fixed_width;
            end
            v = sample_of_width(w);
            r = $urandom_range(0, 39);
            if (r == 0) begin
                v = '1;
            end else if (r == 1) begin
                v = '0;
            end
            send_item(v, 1'b1, end_on_sample && (j == len - 1));
        end
        if (!end_on_sample) begin
            send_item(swip_pkg::SAMPLE_W'($urandom), 1'b0, 1'b1);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        int  k;
        bit  drained;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_sample         = '0;
        s_carries_sample = 1'b0;
        s_array_end      = 1'b0;
        items_sent       = 0;
        width_centre     = swip_pkg::START_WIDTH;
        no_gaps          = 1'b0;
        drained          = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item('0, 1'b0, 1'b1);
        send_item(24'hA5C3F0, 1'b0, 1'b0);
        send_item('1, 1'b1, 1'b1);
        for (k = 0; k < 4; k++) begin
            send_item('1, 1'b1, k == 3);
        end
        for (k = 0; k < 13; k++) begin
            send_item('0, 1'b1, k == 12);
        end
        send_item(24'h000001, 1'b1, 1'b0);
        send_item(24'h000002, 1'b1, 1'b0);
        send_item(24'h800000, 1'b1, 1'b0);
        send_item(24'h7FFFFF, 1'b1, 1'b0);
        send_item(24'h123456, 1'b0, 1'b1);
        drain_stream();

        k = items_sent;
        while (items_sent < k + RANDOM_ITEMS) begin
            send_random_array();
            if (!drained && items_sent >= k + RANDOM_ITEMS / 2) begin
                drain_stream();
                drained = 1'b1;
            end
        end
        s_valid <= 1'b0;

        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[selector_width_integer_packer_unit] OK");
        end else begin
            $display("[selector_width_integer_packer_unit] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/swip_pkg.sv
rtl/core/selector_width_integer_packer_unit.sv
rtl/core/swip_checker.sv
tb/sv/selector_width_integer_packer_checker.sv
tb/sv/selector_width_integer_packer_unit_test.sv
